// ===== rtl/core/one_wire_master_temp_read_core_assert.svh =====
// Assertion macros used by the core's engine module.
`ifndef ONE_WIRE_MASTER_TEMP_READ_CORE_ASSERT_SVH
`define ONE_WIRE_MASTER_TEMP_READ_CORE_ASSERT_SVH

// same-cycle implication
`define OWM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("owm: same-cycle check failed");

// next-cycle implication
`define OWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("owm: next-cycle check failed");

`endif

// ===== rtl/core/owm_pkg.sv =====
`default_nettype none
package owm_pkg;

	localparam int NUM_REGS = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t REG_RESET_LOW = 3'd0;
	localparam cfg_idx_t REG_PRES_WAIT = 3'd1;
	localparam cfg_idx_t REG_RESET_REC = 3'd2;
	localparam cfg_idx_t REG_SLOT_START = 3'd3;
	localparam cfg_idx_t REG_WRITE_HOLD = 3'd4;
	localparam cfg_idx_t REG_READ_SAMPLE = 3'd5;
	localparam cfg_idx_t REG_READ_REC = 3'd6;

	localparam cfg_data_t CFG_RESET [NUM_REGS] = '{
		10'd250, 10'd25, 10'd200, 10'd4, 10'd25, 10'd6, 10'd50
	};

	typedef logic [2:0] func_t;
	localparam func_t FUNC_TICK = 3'd0;
	localparam func_t FUNC_RESET = 3'd1;
	localparam func_t FUNC_WRITE = 3'd2;
	localparam func_t FUNC_READ = 3'd3;
	localparam func_t FUNC_TEMP = 3'd4;

	typedef struct packed {
		func_t func;
		logic [7:0] tx_byte;
		logic line_in;
	} owm_in_t;

	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic presence_level;
		logic [7:0] rx_byte;
		logic [15:0] temp_magnitude;
		logic temp_negative;
	} owm_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/one_wire_master_temp_read_core.sv =====
// One-wire bus master, one input word per bus tick.
// in channel: in_valid/in_stall with in_data (func, tx_byte, line_in). Each
//   accepted word is one tick; func starts a command only while idle.
// out channel: out_valid/out_stall with out_data, exactly one word per
//   accepted input word, in order (drive, busy, done, presence, rx byte,
//   temperature magnitude and sign).
// cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Write timing registers only while the bus engine is idle.
// Path: an accepted word is held in the input stage, then its result in the output register.
// Throughput: one word per cycle while out_stall does not hold the output; the tick
//   engine updates all of its state in one pass between the input stage and the output register.
// Stall: while out_stall holds a waiting result, one more input word is
//   taken into the input stage, then in_stall rises until the output drains.
// Reset: arst_n clears both stages, idles the engine, reloads the timing
//   registers with their defaults and sets the presence level to 1.
`default_nettype none
module one_wire_master_temp_read_core #(
	parameter int TIMER_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire owm_pkg::owm_in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output owm_pkg::owm_out_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire owm_pkg::cfg_idx_t cfg_index,
	input wire owm_pkg::cfg_data_t cfg_data
);
	import owm_pkg::*;

	logic valid_s1;
	owm_in_t item_s1;
	logic out_valid_q;
	owm_out_t out_q;
	logic advance, fire, in_take;
	owm_out_t res;
	logic [NUM_REGS-1:0][TIMER_BITS-1:0] lens;

	assign advance = !out_valid_q || !out_stall;
	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= res;
		end
	end

	owm_cfg #(
		.TIMER_BITS(TIMER_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.lens(lens)
	);

	owm_engine #(
		.TIMER_BITS(TIMER_BITS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.lens(lens),
		.res(res)
	);

endmodule
`default_nettype wire

// ===== rtl/core/owm_cfg.sv =====
`default_nettype none
module owm_cfg #(
	parameter int TIMER_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire owm_pkg::cfg_idx_t wr_index,
	input wire owm_pkg::cfg_data_t wr_data,
	output logic [owm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] lens
);
	import owm_pkg::*;

	localparam int EXT_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
	localparam int MAXV = (1 << TIMER_BITS) - 1;

	cfg_data_t regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= CFG_RESET[i];
			end
		end else if (wr_en && (wr_index < CFG_IDX_W'(NUM_REGS))) begin
			regs_q[wr_index] <= wr_data;
		end
	end

	// zero acts as one tick, large values saturate at the timer range
	always_comb begin
		logic [EXT_W-1:0] ext;
		for (int i = 0; i < NUM_REGS; i++) begin
			ext = EXT_W'(regs_q[i]);
			if (ext == '0) begin
				ext = EXT_W'(1);
			end else if (ext > EXT_W'(MAXV)) begin
				ext = EXT_W'(MAXV);
			end
			lens[i] = ext[TIMER_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/owm_engine.sv =====
`default_nettype none
`include "one_wire_master_temp_read_core_assert.svh"
module owm_engine #(
	parameter int TIMER_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire owm_pkg::owm_in_t item,
	input wire logic [owm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] lens,
	output owm_pkg::owm_out_t res
);
	import owm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_REC,
		PH_WR_START,
		PH_WR_HOLD,
		PH_RD_START,
		PH_RD_WAIT,
		PH_RD_REC
	} phase_t;

	typedef enum logic [1:0] {
		OP_RESET,
		OP_WRITE,
		OP_READ
	} op_kind_t;

	typedef struct packed {
		phase_t ph;
		logic [7:0] sh;
	} op_start_t;

	localparam op_kind_t TEMP_KIND [8] = '{
		OP_RESET, OP_WRITE, OP_WRITE, OP_RESET, OP_WRITE, OP_WRITE, OP_READ, OP_READ
	};
	localparam logic [7:0] TEMP_DATA [8] = '{
		8'h00, 8'hCC, 8'h44, 8'h00, 8'hCC, 8'hBE, 8'h00, 8'h00
	};
	localparam logic [15:0] SIGN_MASK = 16'hF800;
	localparam logic [2:0] TEMP_LAST = 3'd7;
	localparam logic [2:0] TEMP_LOW_STEP = 3'd6;

	function automatic op_start_t begin_op(func_t ac, logic [2:0] seq, logic [7:0] sh);
		op_kind_t kind;
		op_start_t r;
		r.sh = sh;
		if (ac == FUNC_TEMP) begin
			kind = TEMP_KIND[seq];
			r.sh = TEMP_DATA[seq];
		end else if (ac == FUNC_RESET) begin
			kind = OP_RESET;
		end else if (ac == FUNC_WRITE) begin
			kind = OP_WRITE;
		end else begin
			kind = OP_READ;
		end
		case (kind)
			OP_RESET: r.ph = PH_RST_LOW;
			OP_WRITE: r.ph = PH_WR_START;
			default: begin
				r.ph = PH_RD_START;
				r.sh = '0;
			end
		endcase
		return r;
	endfunction

	phase_t phase_q, ph_d, cur;
	logic [TIMER_BITS-1:0] tick_q, tick_d, len;
	logic [2:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [2:0] seq_q, seq_d;
	func_t ac_q, ac_d;
	logic [7:0] low_q, low_d;
	logic pres_q, pres_d;
	logic [7:0] rx_q, rx_d;
	logic [15:0] temp_q, temp_d;
	logic neg_q, neg_d;
	logic drive, busy, done, fin;
	logic [15:0] raw;
	op_start_t bo;

	always_comb begin
		ph_d = phase_q;
		tick_d = tick_q;
		bit_d = bit_q;
		shift_d = shift_q;
		seq_d = seq_q;
		ac_d = ac_q;
		low_d = low_q;
		pres_d = pres_q;
		rx_d = rx_q;
		temp_d = temp_q;
		neg_d = neg_q;
		drive = 1'b0;
		busy = 1'b0;
		done = 1'b0;
		fin = 1'b0;
		cur = PH_IDLE;
		len = '0;
		raw = '0;
		bo = '{ph: PH_IDLE, sh: '0};

		if ((phase_q == PH_IDLE) && (item.func >= FUNC_RESET) && (item.func <= FUNC_TEMP)) begin
			ac_d = item.func;
			seq_d = '0;
			bo = begin_op(item.func, 3'd0, item.tx_byte);
			ph_d = bo.ph;
			shift_d = bo.sh;
			bit_d = '0;
			tick_d = '0;
		end

		if (ph_d != PH_IDLE) begin
			cur = ph_d;
			busy = 1'b1;
			if (cur == PH_RST_LOW || cur == PH_WR_START || cur == PH_RD_START) begin
				drive = 1'b1;
			end else if (cur == PH_WR_HOLD) begin
				drive = ~shift_d[0];
			end
			case (cur)
				PH_RST_LOW: len = lens[REG_RESET_LOW];
				PH_RST_WAIT: len = lens[REG_PRES_WAIT];
				PH_RST_REC: len = lens[REG_RESET_REC];
				PH_WR_START, PH_RD_START: len = lens[REG_SLOT_START];
				PH_WR_HOLD: len = lens[REG_WRITE_HOLD];
				PH_RD_WAIT: len = lens[REG_READ_SAMPLE];
				default: len = lens[REG_READ_REC];
			endcase
			tick_d = tick_d + TIMER_BITS'(1);
			if (tick_d >= len) begin
				tick_d = '0;
				case (cur)
					PH_RST_LOW: ph_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_d = item.line_in;
						ph_d = PH_RST_REC;
					end
					PH_RST_REC: fin = 1'b1;
					PH_WR_START: ph_d = PH_WR_HOLD;
					PH_WR_HOLD: begin
						shift_d = {1'b0, shift_d[7:1]};
						if (bit_d == 3'd7) begin
							fin = 1'b1;
						end else begin
							bit_d = bit_d + 3'd1;
							ph_d = PH_WR_START;
						end
					end
					PH_RD_START: ph_d = PH_RD_WAIT;
					PH_RD_WAIT: begin
						shift_d = {item.line_in, shift_d[7:1]};
						ph_d = PH_RD_REC;
					end
					default: begin
						if (bit_d == 3'd7) begin
							fin = 1'b1;
						end else begin
							bit_d = bit_d + 3'd1;
							ph_d = PH_RD_START;
						end
					end
				endcase
			end
		end

		if (fin) begin
			if (ac_d == FUNC_READ) begin
				rx_d = shift_d;
			end else if (ac_d == FUNC_TEMP) begin
				if (seq_d == TEMP_LOW_STEP) begin
					low_d = shift_d;
					rx_d = shift_d;
				end else if (seq_d == TEMP_LAST) begin
					raw = {shift_d, low_d};
					rx_d = shift_d;
					if ((raw & SIGN_MASK) == SIGN_MASK) begin
						neg_d = 1'b1;
						temp_d = (~raw) + 16'd1;
					end else begin
						neg_d = 1'b0;
						temp_d = raw;
					end
				end
			end
			if ((ac_d != FUNC_TEMP) || (seq_d == TEMP_LAST)) begin
				ph_d = PH_IDLE;
				tick_d = '0;
				done = 1'b1;
			end else begin
				seq_d = seq_d + 3'd1;
				bo = begin_op(ac_d, seq_d, shift_d);
				ph_d = bo.ph;
				shift_d = bo.sh;
				bit_d = '0;
				tick_d = '0;
			end
		end

		res.drive_low = drive;
		res.busy_res = busy;
		res.done_res = done;
		res.presence_level = pres_d;
		res.rx_byte = rx_d;
		res.temp_magnitude = temp_d;
		res.temp_negative = neg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			seq_q <= '0;
			ac_q <= FUNC_TICK;
			low_q <= '0;
			pres_q <= 1'b1;
			rx_q <= '0;
			temp_q <= '0;
			neg_q <= 1'b0;
		end else if (fire) begin
			phase_q <= ph_d;
			tick_q <= tick_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			seq_q <= seq_d;
			ac_q <= ac_d;
			low_q <= low_d;
			pres_q <= pres_d;
			rx_q <= rx_d;
			temp_q <= temp_d;
			neg_q <= neg_d;
		end
	end

	`OWM_ASSERT_IMPLY(a_done_busy, res.done_res, res.busy_res)
	`OWM_ASSERT_IMPLY(a_drive_busy, res.drive_low, res.busy_res)
	`OWM_ASSERT_IMPLY(a_idle_tick, phase_q == PH_IDLE, tick_q == '0)
	`OWM_ASSERT_NEXT(a_stay_idle, fire && (phase_q == PH_IDLE) && ((item.func == FUNC_TICK) || (item.func > FUNC_TEMP)), phase_q == PH_IDLE)

endmodule
`default_nettype wire
